>>> sv/csp_pkg.sv
`default_nettype none

package csp_pkg;

   localparam int TargetWidth  = 19;
   localparam int KhzWidth     = 18;
   localparam int OdWidth      = 3;
   localparam int WordWidth    = 8;
   localparam int OscWidth     = 11;
   localparam int ProductWidth = 22;
   localparam int ScaledWidth  = 19;
   localparam int RecipWidth   = 23;
   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;

   localparam logic [KhzWidth-1:0]     MaxKhzReset  = 18'd160000;
   localparam logic [KhzWidth-1:0]     OldKhzReset  = 18'd12000;
   localparam logic [10:0]             RoundUpAdd   = 11'd1999;
   localparam logic [ProductWidth-1:0] FitLow       = 22'd10000;
   localparam logic [ProductWidth-1:0] FitHigh      = 22'd320000;
   localparam logic [ProductWidth-1:0] WordLowEdge  = 22'd24000;
   localparam logic [ProductWidth-1:0] WordHighEdge = 22'd322000;
   localparam logic [WordWidth-1:0]    WordMin      = 8'd4;
   localparam logic [WordWidth-1:0]    WordMax      = 8'd152;
   localparam logic [WordWidth-1:0]    WordOffset   = 8'd8;
   localparam logic [OdWidth-1:0]      LastStep     = 3'd7;
   // floor(p/2000) == floor((p>>4) * 33555 >> 22) for p below 2^19
   localparam logic [15:0]             QuotRecip    = 16'd33555;
   localparam int                      RecipShift   = 22;

   // register index, at byte address 4*index
   localparam logic [0:0] CsrMaxKhz = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_QUOT,
      ST_SCALE,
      ST_DIV,
      ST_FINISH
   } csp_state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic quot;
      logic scale;
      logic div;
      logic emit;
   } csp_cmd_type;

   typedef struct packed {
      logic hit;
   } csp_status_type;

   // divisor table indexed by od_select
   function automatic logic [3:0] div_of(input logic [OdWidth-1:0] od);
      logic [3:0] d;
      unique case (od)
         3'd0: d = 4'd10;
         3'd1: d = 4'd2;
         3'd2: d = 4'd8;
         3'd3: d = 4'd4;
         3'd4: d = 4'd5;
         3'd5: d = 4'd7;
         3'd6: d = 4'd9;
         default: d = 4'd6;
      endcase
      return d;
   endfunction

   // od_select for each search step, divisors in ascending order
   function automatic logic [OdWidth-1:0] od_ascending(input logic [OdWidth-1:0] idx);
      logic [OdWidth-1:0] od;
      unique case (idx)
         3'd0: od = 3'd1;
         3'd1: od = 3'd3;
         3'd2: od = 3'd4;
         3'd3: od = 3'd7;
         3'd4: od = 3'd5;
         3'd5: od = 3'd2;
         3'd6: od = 3'd6;
         default: od = 3'd0;
      endcase
      return od;
   endfunction

   // 2000/d reduced: numerator factor, leftover divisor 1, 3, 7 or 9
   function automatic logic [10:0] scale_of(input logic [OdWidth-1:0] od);
      logic [10:0] k;
      unique case (od)
         3'd0: k = 11'd200;
         3'd1: k = 11'd1000;
         3'd2: k = 11'd250;
         3'd3: k = 11'd500;
         3'd4: k = 11'd400;
         3'd5: k = 11'd2000;
         3'd6: k = 11'd2000;
         default: k = 11'd1000;
      endcase
      return k;
   endfunction

   // ceil(2^22 / leftover divisor), exact for 19-bit numerators
   function automatic logic [RecipWidth-1:0] recip_of(input logic [OdWidth-1:0] od);
      logic [RecipWidth-1:0] m;
      unique case (od)
         3'd5: m = 23'd599187;
         3'd6: m = 23'd466034;
         3'd7: m = 23'd1398102;
         default: m = 23'd4194304;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

>>> sv/csp_req_if.sv
`default_nettype none

interface csp_req_if;
   import csp_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [TargetWidth-1:0] target_khz;
   logic                   round_up;

   modport source (output valid, output target_khz, output round_up, input ready);
   modport sink   (input valid, input target_khz, input round_up, output ready);
endinterface

`default_nettype wire

>>> sv/csp_rsp_if.sv
`default_nettype none

interface csp_rsp_if;
   import csp_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [OdWidth-1:0]   od_select;
   logic [WordWidth-1:0] vco_word;
   logic [OscWidth-1:0]  osc_field;
   logic [KhzWidth-1:0]  new_khz;
   logic [KhzWidth-1:0]  old_khz;
   logic                 changed;

   modport source (output valid, output od_select, output vco_word, output osc_field,
                   output new_khz, output old_khz, output changed, input ready);
   modport sink   (input valid, input od_select, input vco_word, input osc_field,
                   input new_khz, input old_khz, input changed, output ready);
endinterface

`default_nettype wire

>>> sv/clock_synth_setting_picker.sv
// the divisor search tries one divisor per cycle, then one step each for the /2000
// reciprocal multiply, the word and scale multiply and the final divide
// a new request is taken only in idle, once the last result is in the output register
// reset: synchronous active high, max_khz back to 160000, stored setting back to 12000 khz
`default_nettype none

module clock_synth_setting_picker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   csp_req_if.sink                                  req_bus,
   csp_rsp_if.source                                rsp_bus,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [csp_pkg::CsrAddrWidth-1:0]    paddr,
   input  wire logic [csp_pkg::CsrDataWidth-1:0]    pwdata,
   output logic      [csp_pkg::CsrDataWidth-1:0]    prdata,
   output logic                                     pready
);
   import csp_pkg::*;

   logic [KhzWidth-1:0] max_khz_ff;
   logic                csr_write;
   logic                csr_hit;
   csp_cmd_type         cmd;
   csp_status_type      status;

   // register file: a single cap register, decoded at byte addresses 0 to 3
   assign pready    = 1'b1;
   assign csr_hit   = paddr[CsrAddrWidth-1] == CsrMaxKhz;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_khz_ff <= MaxKhzReset;
      end else if (csr_write && csr_hit) begin
         max_khz_ff <= pwdata[KhzWidth-1:0];
      end
   end

   assign prdata = csr_hit ? {{(CsrDataWidth-KhzWidth){1'b0}}, max_khz_ff} : '0;

   // sequencer: search, quotient, scale, divide, hand off
   csp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic, stored setting and result register
   csp_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .max_khz    (max_khz_ff),
      .target_khz (req_bus.target_khz),
      .round_up   (req_bus.round_up),
      .od_select  (rsp_bus.od_select),
      .vco_word   (rsp_bus.vco_word),
      .osc_field  (rsp_bus.osc_field),
      .new_khz    (rsp_bus.new_khz),
      .old_khz    (rsp_bus.old_khz),
      .changed    (rsp_bus.changed)
   );

   a_cap_write: assert property (@(posedge clock) disable iff (reset)
      (csr_write && csr_hit) |=> max_khz_ff == $past(pwdata[KhzWidth-1:0]))
      else $error("cap register write lost");

   a_cap_hold: assert property (@(posedge clock) disable iff (reset)
      !(csr_write && csr_hit) |=> $stable(max_khz_ff))
      else $error("cap register changed without a write");

   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_bus.ready |-> !(cmd.step || cmd.quot || cmd.scale || cmd.div))
      else $error("request ready while busy");

endmodule

`default_nettype wire

>>> sv/csp_ctrl.sv
`default_nettype none

module csp_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic                    rsp_ready,
   output logic                         rsp_valid,
   input  wire csp_pkg::csp_status_type status,
   output csp_pkg::csp_cmd_type         cmd
);
   import csp_pkg::*;

   csp_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmd.step = 1'b1;
            if (status.hit) begin
               state_in = ST_QUOT;
            end
         end
         ST_QUOT: begin
            cmd.quot = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            cmd.div  = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // wait for the output register to drain
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   a_load_starts_search: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_SEARCH)
      else $error("accepted beat did not start the search");

   a_quot_after_hit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_QUOT |-> $past(state_ff == ST_SEARCH && status.hit))
      else $error("quotient step entered without a search hit");

   a_emit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("result emitted but output not valid");

   a_no_emit_over_pending: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwrote a pending beat");

endmodule

`default_nettype wire

>>> sv/csp_dpath.sv
`default_nettype none

module csp_dpath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire csp_pkg::csp_cmd_type                cmd,
   output csp_pkg::csp_status_type                  status,
   input  wire logic [csp_pkg::KhzWidth-1:0]        max_khz,
   input  wire logic [csp_pkg::TargetWidth-1:0]     target_khz,
   input  wire logic                                round_up,
   output logic      [csp_pkg::OdWidth-1:0]         od_select,
   output logic      [csp_pkg::WordWidth-1:0]       vco_word,
   output logic      [csp_pkg::OscWidth-1:0]        osc_field,
   output logic      [csp_pkg::KhzWidth-1:0]        new_khz,
   output logic      [csp_pkg::KhzWidth-1:0]        old_khz,
   output logic                                     changed
);
   import csp_pkg::*;

   logic [TargetWidth:0]       raised;
   logic [KhzWidth-1:0]        capped;
   logic [KhzWidth-1:0]        target_ff;
   logic [OdWidth-1:0]         idx_ff;
   logic [OdWidth-1:0]         step_od;
   logic [ProductWidth-1:0]    step_prod;
   logic                       fit;
   logic [OdWidth-1:0]         od_ff;
   logic [ProductWidth-1:0]    prod_ff;
   logic [30:0]                quot_full;
   logic [WordWidth-1:0]       q_ff;
   logic                       lo_ff, hi_ff;
   logic [WordWidth-1:0]       word_in, word_ff;
   logic [WordWidth-1:0]       mult_n;
   logic [ScaledWidth-1:0]     v_ff;
   logic [ScaledWidth+RecipWidth-1:0] div_full;
   logic [KhzWidth-1:0]        new_ff;
   logic [KhzWidth-1:0]        old_khz_ff;
   logic                       differs;
   logic [OdWidth-1:0]         out_od_ff;
   logic [WordWidth-1:0]       out_word_ff;
   logic [KhzWidth-1:0]        out_new_ff, out_old_ff;
   logic                       out_changed_ff;

   // round up and cap
   assign raised = {1'b0, target_khz}
                 + (round_up ? {{(TargetWidth-10){1'b0}}, RoundUpAdd} : '0);
   assign capped = (raised > {2'b00, max_khz}) ? max_khz : raised[KhzWidth-1:0];

   // one divisor per step
   assign step_od   = od_ascending(idx_ff);
   assign step_prod = {4'b0000, target_ff} * {18'd0, div_of(step_od)};
   assign fit       = (step_prod > FitLow) && (step_prod <= FitHigh);
   assign status.hit = fit || (idx_ff == LastStep);

   // product / 2000 via shift and reciprocal, valid inside the word window
   assign quot_full = {16'd0, prod_ff[18:4]} * {15'd0, QuotRecip};

   always_comb begin
      priority if (lo_ff) begin
         word_in = WordMin;
      end else if (hi_ff) begin
         word_in = WordMax;
      end else begin
         word_in = q_ff - WordOffset;
      end
   end

   assign mult_n   = word_in + WordOffset;
   assign div_full = {{RecipWidth{1'b0}}, v_ff} * {{ScaledWidth{1'b0}}, recip_of(od_ff)};
   assign differs  = new_ff != old_khz_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         target_ff <= capped;
         idx_ff    <= '0;
      end
      if (cmd.step) begin
         od_ff   <= step_od;
         prod_ff <= step_prod;
         idx_ff  <= idx_ff + 3'd1;
      end
      if (cmd.quot) begin
         q_ff  <= quot_full[RecipShift+WordWidth-1:RecipShift];
         lo_ff <= prod_ff < WordLowEdge;
         hi_ff <= prod_ff >= WordHighEdge;
      end
      if (cmd.scale) begin
         word_ff <= word_in;
         v_ff    <= ScaledWidth'({11'd0, mult_n} * {8'd0, scale_of(od_ff)});
      end
      if (cmd.div) begin
         new_ff <= div_full[RecipShift+KhzWidth-1:RecipShift];
      end
      if (cmd.emit) begin
         out_od_ff      <= od_ff;
         out_word_ff    <= word_ff;
         out_new_ff     <= new_ff;
         out_old_ff     <= old_khz_ff;
         out_changed_ff <= differs;
      end
   end

   // frequency of the stored setting
   always_ff @(posedge clock) begin
      if (reset) begin
         old_khz_ff <= OldKhzReset;
      end else if (cmd.emit && differs) begin
         old_khz_ff <= new_ff;
      end
   end

   assign od_select = out_od_ff;
   assign vco_word  = out_word_ff;
   assign osc_field = {out_od_ff, out_word_ff};
   assign new_khz   = out_new_ff;
   assign old_khz   = out_old_ff;
   assign changed   = out_changed_ff;

   a_word_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.scale |=> (word_ff >= WordMin && word_ff <= WordMax))
      else $error("vco word outside its range");

   a_new_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.div |=> new_ff <= 18'd160000)
      else $error("achieved frequency out of range");

   a_setting_tracks: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && differs) |=> old_khz_ff == $past(new_ff))
      else $error("stored setting not updated on change");

   a_held_when_equal: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && !differs) |=> $stable(old_khz_ff))
      else $error("stored setting moved on equal frequency");

endmodule

`default_nettype wire

>>> tb/csp_checker.sv
module csp_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   csp_req_if                                    req_mon,
   csp_rsp_if                                    rsp_mon,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic                             pready,
   input  wire logic [csp_pkg::CsrAddrWidth-1:0] paddr,
   input  wire logic [csp_pkg::CsrDataWidth-1:0] pwdata,
   output int                                    mismatch_count,
   output int                                    open_count,
   output int                                    settings_seen,
   output int                                    changes_seen
);
   import csp_pkg::*;

   typedef struct packed {
      logic [OdWidth-1:0]   od_select;
      logic [WordWidth-1:0] vco_word;
      logic [OscWidth-1:0]  osc_field;
      logic [KhzWidth-1:0]  new_khz;
      logic [KhzWidth-1:0]  old_khz;
      logic                 changed;
   } setting_type;

   logic [KhzWidth-1:0]  cap_khz;
   logic [WordWidth-1:0] held_word;
   logic [OdWidth-1:0]   held_od;
   setting_type          expected_settings[$];

   function automatic int unsigned divisor_for(input logic [OdWidth-1:0] od);
      case (od)
         3'd0:    return 10;
         3'd1:    return 2;
         3'd2:    return 8;
         3'd3:    return 4;
         3'd4:    return 5;
         3'd5:    return 7;
         3'd6:    return 9;
         default: return 6;
      endcase
   endfunction

   // divisors tried smallest first: 2,4,5,6,7,8,9,10
   function automatic logic [OdWidth-1:0] search_od(input int step);
      case (step)
         0:       return 3'd1;
         1:       return 3'd3;
         2:       return 3'd4;
         3:       return 3'd7;
         4:       return 3'd5;
         5:       return 3'd2;
         6:       return 3'd6;
         default: return 3'd0;
      endcase
   endfunction

   function automatic int unsigned khz_of(input logic [WordWidth-1:0] word,
                                          input logic [OdWidth-1:0] od);
      return (32'd2000 * (32'(word) + 32'd8)) / divisor_for(od);
   endfunction

   function automatic setting_type pick_setting(input logic [TargetWidth-1:0] target,
                                                input logic up);
      setting_type          s;
      int unsigned          request;
      int unsigned          product;
      int unsigned          quot;
      logic [OdWidth-1:0]   od;
      logic [WordWidth-1:0] word;
      logic                 hit;
      int                   step;
      request = 32'(target) + (up ? 32'd1999 : 32'd0);
      if (request > 32'(cap_khz))
         request = 32'(cap_khz);
      hit = 1'b0;
      od = '0;
      product = 0;
      for (step = 0; step < 8; step++) begin
         if (!hit) begin
            od = search_od(step);
            product = request * divisor_for(od);
            hit = (product > 32'd10000) && (product <= 32'd320000);
         end
      end
      // no fit leaves the last divisor (10) and its product
      quot = product / 32'd2000;
      if (quot < 12)
         word = 8'd4;
      else if (quot > 160)
         word = 8'd152;
      else
         word = WordWidth'(quot - 32'd8);
      s.od_select = od;
      s.vco_word  = word;
      s.osc_field = {od, word};
      s.new_khz   = KhzWidth'(khz_of(word, od));
      s.old_khz   = KhzWidth'(khz_of(held_word, held_od));
      s.changed   = (s.new_khz != s.old_khz);
      return s;
   endfunction

   function automatic int field_differs(input string field, input int unsigned want,
                                        input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      setting_type got;
      setting_type want;
      if (reset) begin
         cap_khz   = MaxKhzReset;
         held_word = 8'd4;
         held_od   = 3'd1;
         expected_settings.delete();
      end else begin
         if (psel && penable && pwrite && pready
             && paddr == CsrAddrWidth'(4 * CsrMaxKhz))
            cap_khz = pwdata[KhzWidth-1:0];

         if (rsp_mon.valid && rsp_mon.ready) begin
            got.od_select = rsp_mon.od_select;
            got.vco_word  = rsp_mon.vco_word;
            got.osc_field = rsp_mon.osc_field;
            got.new_khz   = rsp_mon.new_khz;
            got.old_khz   = rsp_mon.old_khz;
            got.changed   = rsp_mon.changed;
            settings_seen++;
            if (expected_settings.size() == 0) begin
               $display("%0t: result beat with nothing expected, expected none, actual %h",
                        $time, got);
               mismatch_count++;
            end else begin
               want = expected_settings.pop_front();
               mismatch_count += field_differs("od_select", want.od_select, got.od_select);
               mismatch_count += field_differs("vco_word", want.vco_word, got.vco_word);
               mismatch_count += field_differs("osc_field", want.osc_field, got.osc_field);
               mismatch_count += field_differs("new_khz", want.new_khz, got.new_khz);
               mismatch_count += field_differs("old_khz", want.old_khz, got.old_khz);
               mismatch_count += field_differs("changed", want.changed, got.changed);
               if (want.changed)
                  changes_seen++;
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            want = pick_setting(req_mon.target_khz, req_mon.round_up);
            if (want.changed) begin
               held_word = want.vco_word;
               held_od   = want.od_select;
            end
            expected_settings.push_back(want);
         end
      end
      open_count = expected_settings.size();
   end

endmodule

>>> tb/tb.sv
module tb;
   import csp_pkg::*;

   // generous bound, a correct run stays well within it
   localparam int CycleLimit  = 1000000;
   // long result back-pressure once this many result beats went by
   localparam int HoldBeat    = 300;
   localparam int HoldCycles  = 400;
   // quiet cycles before a register write, above the worst block latency
   localparam int SettleDelay = 16;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [CsrAddrWidth-1:0] paddr;
   logic [CsrDataWidth-1:0] pwdata;
   logic [CsrDataWidth-1:0] prdata;
   logic                    pready;

   int mismatch_count;
   int open_count;
   int settings_seen;
   int changes_seen;
   int cycle_count = 0;
   int rsp_beats = 0;

   // idle pattern state: runs of items with or without random waits
   int                     sender_run = 0;
   bit                     sender_quiet = 1'b0;
   int                     receiver_run = 0;
   bit                     receiver_quiet = 1'b0;
   logic [TargetWidth-1:0] last_target = '0;

   csp_req_if req_bus ();
   csp_rsp_if rsp_bus ();

   clock_synth_setting_picker u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   csp_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .mismatch_count (mismatch_count),
      .open_count     (open_count),
      .settings_seen  (settings_seen),
      .changes_seen   (changes_seen)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // random wait length for one item, but whole runs with no waiting at all
   task automatic draw_wait(inout int run_left, inout bit quiet, output int cycles);
      if (run_left == 0) begin
         run_left = $urandom_range(20, 80);
         quiet = ($urandom_range(0, 3) == 0);
      end
      run_left--;
      cycles = quiet ? 0 : $urandom_range(0, 16);
   endtask

   // one request beat; valid stays up into the next call when there is no gap
   task automatic send_request(input logic [TargetWidth-1:0] target, input logic up);
      int gap;
      draw_wait(sender_run, sender_quiet, gap);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.target_khz <= target;
      req_bus.round_up   <= up;
      last_target = target;
      @(posedge clock iff req_bus.ready);
      @(negedge clock);
   endtask

   // setup then access phase; junk in the unused upper data bits
   task automatic write_max_khz(input logic [KhzWidth-1:0] cap);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CsrAddrWidth'(4 * CsrMaxKhz);
      pwdata  <= ($urandom() << KhzWidth) | CsrDataWidth'(cap);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock iff pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // drain: every expected result back, then let the block go quiet
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (open_count != 0)
         @(negedge clock);
      repeat (SettleDelay) @(negedge clock);
   endtask

   // targets aimed at the interesting spots: fit limits, cap, word limits, repeats
   function automatic logic [TargetWidth-1:0] draw_target(input int cap);
      int v;
      int d;
      d = $urandom_range(2, 10);
      case ($urandom_range(0, 7))
         0: v = $urandom_range(0, 524287);
         1: v = $urandom_range(0, 400000);
         2: v = $urandom_range(0, 12000);
         3: begin
            // just around a fit limit for some divisor, maybe before round-up
            v = (($urandom_range(0, 1) != 0) ? 10000 : 320000) / d;
            v = v + int'($urandom_range(0, 6)) - 3;
            if ($urandom_range(0, 1) != 0)
               v = v - 1999;
         end
         4: v = cap + int'($urandom_range(0, 4200)) - 2100;
         5: begin
            // products near the low word saturation point or near 336000
            v = (($urandom_range(0, 1) != 0) ? 24000 : 336000) / d;
            v = v + int'($urandom_range(0, 4)) - 2;
         end
         default: v = int'(last_target) + int'($urandom_range(0, 3));
      endcase
      if (v < 0)
         v = 0;
      if (v > 524287)
         v = 524287;
      return TargetWidth'(v);
   endfunction

   // response side: random stalls plus one long hold-off
   initial begin : receiver
      int stall;
      bit held;
      held = 1'b0;
      @(negedge clock iff !reset);
      forever begin
         if (!held && rsp_beats >= HoldBeat) begin
            // sender keeps offering meanwhile, so the block backs up into its input
            held = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HoldCycles) @(negedge clock);
         end
         draw_wait(receiver_run, receiver_quiet, stall);
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock iff rsp_bus.valid);
         rsp_beats++;
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int                  phase;
      int                  count;
      logic [KhzWidth-1:0] cap;

      // everything known from the start
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.target_khz = '0;
      req_bus.round_up   = 1'b0;
      rsp_bus.ready      = 1'b0;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, cap at its reset value
      send_request(19'd0, 1'b0);
      send_request(19'd0, 1'b1);
      // tiny requests: 1000 fits nothing and falls back to divisor 10, the rest sit at the fit limit for 10 and 9
      send_request(19'd1000, 1'b0);
      send_request(19'd1001, 1'b0);
      send_request(19'd1111, 1'b0);
      send_request(19'd1112, 1'b0);
      // fit lower limit for divisors 4 and 2
      send_request(19'd2500, 1'b0);
      send_request(19'd2501, 1'b0);
      send_request(19'd5000, 1'b0);
      send_request(19'd5001, 1'b0);
      // same frequency twice, second one leaves the setting alone
      send_request(19'd6000, 1'b0);
      send_request(19'd6000, 1'b0);
      // word floor
      send_request(19'd11999, 1'b0);
      send_request(19'd12000, 1'b1);
      // round-up into the cap, then requests far above it
      send_request(19'd158001, 1'b1);
      send_request(19'd160000, 1'b0);
      send_request(19'd400000, 1'b0);
      send_request(19'd400000, 1'b1);
      send_request(19'h7FFFF, 1'b1);
      settle();

      // directed, cap beyond its nominal range
      write_max_khz(18'h3FFFF);
      send_request(19'd32000, 1'b0);
      // nothing fits, word 152 on divisor 10: same 32000 khz, new pair reported
      send_request(19'd200000, 1'b0);
      send_request(19'd168000, 1'b0);
      send_request(19'd160001, 1'b0);
      send_request(19'd262143, 1'b1);
      send_request(19'h7FFFF, 1'b0);
      settle();

      // random phases, one cap setting each
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0:       cap = MaxKhzReset;
            1:       cap = 18'd12000;
            2:       cap = '0;
            3:       cap = KhzWidth'($urandom_range(12000, 160000));
            4:       cap = 18'h3FFFF;
            default: cap = KhzWidth'($urandom_range(0, 262143));
         endcase
         write_max_khz(cap);
         // a zero cap makes every result the same, keep that phase short
         count = (phase == 2) ? 100 : 350;
         repeat (count) send_request(draw_target(int'(cap)), 1'($urandom_range(0, 1)));
         settle();
      end

      $display("%0d settings checked over 8 cap values, %0d of them changed the clock",
               settings_seen, changes_seen);
      $display("directed corners, random targets both rounding ways, one long result stall");
      if (mismatch_count == 0 && open_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> clock_synth_setting_picker.f
sv/csp_pkg.sv
sv/csp_req_if.sv
sv/csp_rsp_if.sv
sv/csp_ctrl.sv
sv/csp_dpath.sv
sv/clock_synth_setting_picker.sv
tb/csp_checker.sv
tb/tb.sv
